/* design/um32_pkg.sv */
// ----------------------------------------------------------------------------
// um32_pkg: shared types and constants of the UM-32 execute unit.
// Holds the opcodes, request codes and the transaction payload structs.
// ----------------------------------------------------------------------------
package um32_pkg;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned OpShift  = 28;
  localparam int unsigned ImmRegShift = 25;
  localparam logic [31:0] ImmMask  = 32'h01FF_FFFF;
  localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [1:0] {
    KIND_INSTR = 2'd0,
    KIND_READ  = 2'd1,
    KIND_ALLOC = 2'd2,
    KIND_INPUT = 2'd3
  } item_kind_e;

  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,
    OP_READ  = 4'd1,
    OP_WRITE = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_ALLOC = 4'd8,
    OP_FREE  = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_LOAD  = 4'd12,
    OP_IMM   = 4'd13,
    OP_BAD0  = 4'd14,
    OP_BAD1  = 4'd15
  } opcode_e;

  typedef enum logic [3:0] {
    REQ_NONE    = 4'd0,
    REQ_READ    = 4'd1,
    REQ_WRITE   = 4'd2,
    REQ_ALLOC   = 4'd3,
    REQ_FREE    = 4'd4,
    REQ_OUTPUT  = 4'd5,
    REQ_INPUT   = 4'd6,
    REQ_LOAD    = 4'd7,
    REQ_HALT    = 4'd8,
    REQ_INVALID = 4'd9
  } request_kind_e;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [31:0] instruction_word;
    logic [31:0] reply_value;
    logic        input_ended;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  request_kind;
    logic [31:0] array_id;
    logic [31:0] array_offset;
    logic [31:0] data_value;
    logic [31:0] new_pc;
  } out_item_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic                is_reply;
    logic [3:0]          op;
    logic [RegIdxW-1:0]  ra;
    logic [RegIdxW-1:0]  rb;
    logic [RegIdxW-1:0]  rc;
    logic [31:0]         value;   // immediate, or reply value already shaped
  } work_t;

endpackage

/* design/um32_front.sv */
// ----------------------------------------------------------------------------
// um32_front: input stage of the UM-32 execute unit.
// Registers one input transaction, decodes its fields and shapes reply values.
// ----------------------------------------------------------------------------
module um32_front import um32_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      wk_valid_o,
  input  logic      wk_ready_i,
  output work_t     wk_o
);

  logic  full_q;
  work_t wk_q, wk_d;

  assign in_ready_o = !full_q || wk_ready_i;
  assign wk_valid_o = full_q;
  assign wk_o       = wk_q;

  always_comb begin
    wk_d.is_reply = (in_item_i.item_kind != KIND_INSTR);
    wk_d.op       = in_item_i.instruction_word[31:OpShift];
    wk_d.ra       = in_item_i.instruction_word[8:6];
    wk_d.rb       = in_item_i.instruction_word[5:3];
    wk_d.rc       = in_item_i.instruction_word[2:0];
    wk_d.value    = in_item_i.instruction_word & ImmMask;
    if (wk_d.is_reply) begin
      wk_d.value = in_item_i.reply_value;
      if (in_item_i.item_kind == KIND_INPUT) begin
        wk_d.value = in_item_i.input_ended ? AllOnes
                                           : {24'd0, in_item_i.reply_value[7:0]};
      end
    end else if (wk_d.op == OP_IMM) begin
      wk_d.ra = in_item_i.instruction_word[ImmRegShift+2:ImmRegShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_ready_o) begin
      full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      wk_q <= wk_d;
    end
  end

endmodule

/* design/um32_back.sv */
// ----------------------------------------------------------------------------
// um32_back: execution stage of the UM-32 execute unit.
// Holds the register file, runs each work item and emits one result.
// ----------------------------------------------------------------------------
module um32_back import um32_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wk_valid_i,
  output logic      wk_ready_o,
  input  work_t     wk_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  state_e      state_q;
  logic [31:0] rf_q [RegCount];
  logic        pend_q;
  logic [RegIdxW-1:0] pend_reg_q;
  logic        stop_q;
  logic        ovalid_q;
  out_item_t   out_q;
  logic [RegIdxW-1:0] dst_q;
  logic [31:0] prod_q;
  logic [31:0] quo_q, rem_q, dvd_q, dvs_q;
  logic [5:0]  cnt_q;

  logic [31:0] va, vb, vc;
  logic        take;
  out_item_t   res;
  logic        wr_en;
  logic [RegIdxW-1:0] wr_idx;
  logic [31:0] wr_val;
  logic        raise;
  logic [RegIdxW-1:0] raise_reg;
  logic        stop_op;
  logic        long_op;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  assign va = rf_q[wk_i.ra];
  assign vb = rf_q[wk_i.rb];
  assign vc = rf_q[wk_i.rc];
  assign wk_ready_o  = (state_q == ST_IDLE) && (!ovalid_q || out_ready_i);
  assign take        = wk_ready_o && wk_valid_i;
  assign out_valid_o = ovalid_q;
  assign out_item_o  = out_q;

  always_comb begin
    res       = '0;
    wr_en     = 1'b0;
    wr_idx    = wk_i.ra;
    wr_val    = '0;
    raise     = 1'b0;
    raise_reg = wk_i.ra;
    stop_op   = 1'b0;
    long_op   = 1'b0;
    if (!stop_q && !wk_i.is_reply) begin
      unique case (opcode_e'(wk_i.op))
        OP_CMOV: begin
          wr_en  = (vc != 32'd0);
          wr_val = vb;
        end
        OP_READ: begin
          res.request_kind = REQ_READ;
          res.array_id     = vb;
          res.array_offset = vc;
          raise            = 1'b1;
          raise_reg        = wk_i.ra;
        end
        OP_WRITE: begin
          res.request_kind = REQ_WRITE;
          res.array_id     = va;
          res.array_offset = vb;
          res.data_value   = vc;
        end
        OP_ADD: begin
          wr_en  = 1'b1;
          wr_val = vb + vc;
        end
        OP_MUL, OP_DIV: long_op = 1'b1;
        OP_NAND: begin
          wr_en  = 1'b1;
          wr_val = ~(vb & vc);
        end
        OP_HALT: begin
          res.request_kind = REQ_HALT;
          stop_op          = 1'b1;
        end
        OP_ALLOC: begin
          res.request_kind = REQ_ALLOC;
          res.data_value   = vc;
          raise            = 1'b1;
          raise_reg        = wk_i.rb;
        end
        OP_FREE: begin
          res.request_kind = REQ_FREE;
          res.array_id     = vc;
        end
        OP_OUT: begin
          res.request_kind = REQ_OUTPUT;
          res.data_value   = {24'd0, vc[7:0]};
        end
        OP_IN: begin
          res.request_kind = REQ_INPUT;
          raise            = 1'b1;
          raise_reg        = wk_i.rc;
        end
        OP_LOAD: begin
          res.request_kind = REQ_LOAD;
          res.array_id     = vb;
          res.new_pc       = vc;
        end
        OP_IMM: begin
          wr_en  = 1'b1;
          wr_val = wk_i.value;
        end
        OP_BAD0, OP_BAD1: begin
          res.request_kind = REQ_INVALID;
          stop_op          = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rem_sh  = {rem_q, dvd_q[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_q     <= 1'b0;
      pend_reg_q <= '0;
      stop_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      out_q      <= '0;
      dst_q      <= '0;
      prod_q     <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      dvd_q      <= '0;
      dvs_q      <= '0;
      cnt_q      <= '0;
      for (int i = 0; i < RegCount; i++) rf_q[i] <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            // Multiply and divide post their result from their own states.
            ovalid_q <= !long_op;
            out_q    <= res;
            if (stop_q) begin
              // Stopped core ignores everything.
            end else if (wk_i.is_reply) begin
              if (pend_q) rf_q[pend_reg_q] <= wk_i.value;
              pend_q <= 1'b0;
            end else begin
              pend_q <= raise;
              if (raise) pend_reg_q <= raise_reg;
              if (wr_en) rf_q[wr_idx] <= wr_val;
              if (stop_op) stop_q <= 1'b1;
              if (long_op) begin
                dst_q <= wk_i.ra;
                if (opcode_e'(wk_i.op) == OP_MUL) begin
                  prod_q  <= vb * vc;
                  state_q <= ST_MUL;
                end else begin
                  dvd_q   <= vb;
                  dvs_q   <= vc;
                  rem_q   <= '0;
                  quo_q   <= '0;
                  cnt_q   <= 6'(DivSteps);
                  state_q <= ST_DIV;
                end
              end
            end
          end else if (out_ready_i) begin
            ovalid_q <= 1'b0;
          end
        end
        ST_MUL: begin
          rf_q[dst_q] <= prod_q;
          ovalid_q    <= 1'b1;
          out_q       <= '0;
          state_q     <= ST_IDLE;
        end
        ST_DIV: begin
          if (dvs_q == 32'd0) begin
            ovalid_q <= 1'b1;
            out_q    <= '0;
            state_q  <= ST_IDLE;
          end else if (cnt_q == 6'd0) begin
            rf_q[dst_q] <= quo_q;
            ovalid_q    <= 1'b1;
            out_q       <= '0;
            state_q     <= ST_IDLE;
          end else begin
            dvd_q <= {dvd_q[30:0], 1'b0};
            if (!rem_sub[32]) begin
              rem_q <= rem_sub[31:0];
              quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= rem_sh[31:0];
              quo_q <= {quo_q[30:0], 1'b0};
            end
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A result never appears while multiply or divide still runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !ovalid_q) else $error("result during long op");
  // A stopped core stays stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q) else $error("stop flag cleared");
  // Work is only taken when the previous result has left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (!ovalid_q || out_ready_i)) else $error("result overwritten");

endmodule

/* design/um32_instruction_execute_unit.sv */
// ----------------------------------------------------------------------------
// um32_instruction_execute_unit: execute core of the 32-bit universal machine.
// Decodes instructions and replies, runs ALU work, emits outside requests.
// ----------------------------------------------------------------------------
//  Channel | Signals                         | Direction
//  --------+---------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_item_i   | into core
//  out     | out_valid_o, out_ready_i, out_item_o| out of core
//
// Most transactions pass through two registers: the front register, then the
// back stage that reads the register file and writes the result register.
// Multiply adds the ST_MUL state; divide iterates one quotient bit per cycle
// in ST_DIV of the back stage and skips the iteration on a zero divisor.
// Reset clears the register file, the pending-reply and stopped flags.
// The front register lets a new transaction wait while the back stage or a
// stalled output holds the previous one.
module um32_instruction_execute_unit import um32_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic  wk_valid;
  logic  wk_ready;
  work_t wk;

  // Front: capture and classify one transaction.
  um32_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .wk_valid_o (wk_valid),
    .wk_ready_i (wk_ready),
    .wk_o       (wk)
  );

  // Back: execute it against the register file.
  um32_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wk_valid_i  (wk_valid),
    .wk_ready_o  (wk_ready),
    .wk_i        (wk),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
